/* sv/rtspmf_pkg.sv */
// rtspmf_pkg: shared codes, character constants and header scan state for the
// rtsp message framer. No dependencies.
`timescale 1ns / 1ps

package rtspmf_pkg;

   localparam int LENGTH_BITS_DEFAULT = 31;
   localparam logic [30:0] BODY_LIMIT_RESET = 31'd1048576;
   localparam logic [3:0] KEY_LEN = 4'd15;

   // region codes of a result beat
   localparam logic [1:0] REGION_HEADER  = 2'd0;
   localparam logic [1:0] REGION_BODY    = 2'd1;
   localparam logic [1:0] REGION_DISCARD = 2'd2;

   // error codes of a result beat
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_NO_DIGITS = 2'd1;
   localparam logic [1:0] ERR_NEGATIVE  = 2'd2;
   localparam logic [1:0] ERR_LIMIT     = 2'd3;

   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5a;
   localparam logic [7:0] CH_C     = 8'h63;

   typedef enum logic [2:0] {
      NS_NONE   = 3'd0,
      NS_SKIP   = 3'd1,
      NS_SIGN   = 3'd2,
      NS_DIGITS = 3'd3,
      NS_DONE   = 3'd4,
      NS_FAIL   = 3'd5
   } num_stage_type;

   typedef struct packed {
      logic [1:0]    term;
      logic [3:0]    key_pos;
      num_stage_type stage;
      logic          negative;
   } hdr_state_type;

   localparam hdr_state_type HDR_CLEAR = '{
      term: 2'd0, key_pos: 4'd0, stage: NS_NONE, negative: 1'b0
   };

   // lower-case "content-length:"
   function automatic logic [7:0] keyword_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = 8'h63; // c
         4'd1:    ch = 8'h6f; // o
         4'd2:    ch = 8'h6e; // n
         4'd3:    ch = 8'h74; // t
         4'd4:    ch = 8'h65; // e
         4'd5:    ch = 8'h6e; // n
         4'd6:    ch = 8'h74; // t
         4'd7:    ch = 8'h2d; // -
         4'd8:    ch = 8'h6c; // l
         4'd9:    ch = 8'h65; // e
         4'd10:   ch = 8'h6e; // n
         4'd11:   ch = 8'h67; // g
         4'd12:   ch = 8'h74; // t
         4'd13:   ch = 8'h68; // h
         4'd14:   ch = 8'h3a; // :
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

/* sv/rtspmf_req_if.sv */
// rtspmf_req_if: input byte channel of the rtsp message framer.
// Valid/ready handshake; no package dependency.
`timescale 1ns / 1ps

interface rtspmf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       chunk_last;

   modport source (output valid, output data_byte, output chunk_last, input ready);
   modport sink   (input valid, input data_byte, input chunk_last, output ready);
endinterface

/* sv/rtspmf_rsp_if.sv */
// rtspmf_rsp_if: result channel of the rtsp message framer.
// Valid/ready handshake; no package dependency.
`timescale 1ns / 1ps

interface rtspmf_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [1:0]  region;
   logic        message_end;
   logic [30:0] body_length;
   logic [1:0]  error_code;
   logic        chunk_failed;

   modport source (output valid, output out_byte, output region, output message_end,
                   output body_length, output error_code, output chunk_failed,
                   input ready);
   modport sink   (input valid, input out_byte, input region, input message_end,
                   input body_length, input error_code, input chunk_failed,
                   output ready);
endinterface

/* sv/rtsp_message_framer.sv */
// rtsp_message_framer: tags each rtsp stream byte as header, body or discarded
// and marks message ends. Depends on rtspmf_pkg, rtspmf_req_if, rtspmf_rsp_if
// and rtspmf_header_scan.
// path: an accepted input beat is held in the input register, then in the result register
// throughput: one beat per cycle while rsp_chan.ready does not stall; the per-byte scan and the
//   decimal accumulate sit in the single stage between input and result registers
// reset: synchronous, active high; clears both stage valids, the parser
//   state and sets body_limit to 1048576
`timescale 1ns / 1ps

module rtsp_message_framer import rtspmf_pkg::*; #(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   rtspmf_req_if.sink         req_chan,
   rtspmf_rsp_if.source       rsp_chan,
   input  logic               csr_wr_en,
   input  logic [30:0]        csr_wr_data
);

   // parser phase
   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_BODY    = 2'd1,
      PH_DISCARD = 2'd2
   } phase_type;

   // input register stage
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // result register stage
   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic [1:0]  out_region_ff;
   logic        out_mend_ff;
   logic [30:0] out_blen_ff;
   logic [1:0]  out_err_ff;
   logic        out_cfail_ff;

   // parser state and its next values
   phase_type              phase_ff, phase_in;
   hdr_state_type          hdr_ff, hdr_in;
   logic [LENGTH_BITS-1:0] value_ff, value_in;
   logic [LENGTH_BITS-1:0] body_left_ff, body_left_in;
   logic                   chunk_error_ff, chunk_error_in;
   logic [30:0]            body_limit_ff;

   // result beat under construction
   logic [1:0]  region_in;
   logic        mend_in;
   logic [30:0] blen_in;
   logic [1:0]  err_in;
   logic        cfail_in;

   // header scanner outputs
   hdr_state_type          scan_hdr;
   logic [LENGTH_BITS-1:0] scan_value;
   logic                   scan_end;

   logic out_adv;
   logic in_adv;

   // result slot frees when empty or taken this cycle; input stage moves into it
   assign out_adv        = !out_valid_ff || rsp_chan.ready;
   assign in_adv         = in_valid_ff && out_adv;
   assign req_chan.ready = !in_valid_ff || out_adv;

   rtspmf_header_scan #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_scan (
      .hdr_cur    (hdr_ff),
      .value_cur  (value_ff),
      .data_byte  (in_byte_ff),
      .hdr_nxt    (scan_hdr),
      .value_nxt  (scan_value),
      .header_end (scan_end)
   );

   always_comb begin
      phase_in       = phase_ff;
      hdr_in         = hdr_ff;
      value_in       = value_ff;
      body_left_in   = body_left_ff;
      chunk_error_in = chunk_error_ff;
      region_in      = REGION_HEADER;
      mend_in        = 1'b0;
      blen_in        = '0;
      err_in         = ERR_NONE;

      case (phase_ff)
         PH_BODY: begin
            region_in = REGION_BODY;
            if (body_left_ff != '0) begin
               body_left_in = body_left_ff - LENGTH_BITS'(1);
            end
            // last body beat ends the message
            if (body_left_in == '0) begin
               mend_in  = 1'b1;
               phase_in = PH_HEADER;
            end
         end
         PH_DISCARD: begin
            region_in = REGION_DISCARD;
         end
         default: begin
            // header phase, the unused code behaves the same
            phase_in = PH_HEADER;
            hdr_in   = scan_hdr;
            value_in = scan_value;
            if (scan_end) begin
               if (scan_hdr.stage == NS_NONE) begin
                  // no keyword, the header alone is the message
                  mend_in = 1'b1;
               end else if (scan_hdr.stage != NS_DIGITS && scan_hdr.stage != NS_DONE) begin
                  err_in = ERR_NO_DIGITS;
               end else if (scan_hdr.negative && scan_value != '0) begin
                  err_in = ERR_NEGATIVE;
               end else if (31'(scan_value) > body_limit_ff) begin
                  err_in = ERR_LIMIT;
               end else begin
                  blen_in = 31'(scan_value);
                  if (scan_value == '0) begin
                     mend_in = 1'b1;
                  end else begin
                     body_left_in = scan_value;
                     phase_in     = PH_BODY;
                  end
               end
               hdr_in   = HDR_CLEAR;
               value_in = '0;
               if (err_in != ERR_NONE) begin
                  phase_in       = PH_DISCARD;
                  chunk_error_in = 1'b1;
               end
            end
         end
      endcase

      // chunk status includes an error raised on this very beat
      cfail_in = in_last_ff && chunk_error_in;

      // chunk boundary: drop the error flag and resync after a discard
      if (in_last_ff) begin
         chunk_error_in = 1'b0;
         if (phase_in == PH_DISCARD) begin
            phase_in = PH_HEADER;
            hdr_in   = HDR_CLEAR;
            value_in = '0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         phase_ff       <= PH_HEADER;
         hdr_ff         <= HDR_CLEAR;
         value_ff       <= '0;
         body_left_ff   <= '0;
         chunk_error_ff <= 1'b0;
         body_limit_ff  <= BODY_LIMIT_RESET;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_adv) begin
            out_valid_ff <= in_valid_ff;
         end
         if (in_adv) begin
            phase_ff       <= phase_in;
            hdr_ff         <= hdr_in;
            value_ff       <= value_in;
            body_left_ff   <= body_left_in;
            chunk_error_ff <= chunk_error_in;
         end
         if (csr_wr_en) begin
            body_limit_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.chunk_last;
      end
      if (in_adv) begin
         out_byte_ff   <= in_byte_ff;
         out_region_ff <= region_in;
         out_mend_ff   <= mend_in;
         out_blen_ff   <= blen_in;
         out_err_ff    <= err_in;
         out_cfail_ff  <= cfail_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.out_byte     = out_byte_ff;
   assign rsp_chan.region       = out_region_ff;
   assign rsp_chan.message_end  = out_mend_ff;
   assign rsp_chan.body_length  = out_blen_ff;
   assign rsp_chan.error_code   = out_err_ff;
   assign rsp_chan.chunk_failed = out_cfail_ff;

   // body phase always has bytes left to count
   a_body_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> body_left_ff != '0)
      else $error("body phase with zero bytes left");

   // discarding only happens inside a failed chunk
   a_discard_flag: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DISCARD |-> chunk_error_ff)
      else $error("discard phase without chunk error");

   // a blocked input beat is held in the input stage
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_adv |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("input stage lost a stalled beat");

endmodule

/* sv/rtspmf_header_scan.sv */
// rtspmf_header_scan: per-byte next state of the header scanners (terminator,
// keyword, length number). Combinational; uses rtspmf_pkg.
`timescale 1ns / 1ps

module rtspmf_header_scan import rtspmf_pkg::*; #(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  hdr_state_type          hdr_cur,
   input  logic [LENGTH_BITS-1:0] value_cur,
   input  logic [7:0]             data_byte,
   output hdr_state_type          hdr_nxt,
   output logic [LENGTH_BITS-1:0] value_nxt,
   output logic                   header_end
);

   logic [7:0]             lower;
   logic                   is_digit;
   logic                   is_space;
   logic                   num_step;
   logic [LENGTH_BITS+3:0] wide;
   logic [LENGTH_BITS+3:0] accum;
   logic [LENGTH_BITS-1:0] accum_sat;
   logic [2:0]             term_nxt;

   always_comb begin
      lower    = (data_byte inside {[CH_UP_A:CH_UP_Z]}) ? data_byte + 8'd32 : data_byte;
      is_digit = data_byte inside {[CH_ZERO:CH_NINE]};
      is_space = (data_byte == CH_SPACE) || (data_byte inside {[8'd9:8'd13]});
      // value * 10 + digit, saturating at all ones
      wide      = (LENGTH_BITS + 4)'(value_cur);
      accum     = (wide << 3) + (wide << 1) + (LENGTH_BITS + 4)'(data_byte[3:0]);
      accum_sat = (|accum[LENGTH_BITS+3:LENGTH_BITS]) ? '1 : accum[LENGTH_BITS-1:0];
   end

   always_comb begin
      hdr_nxt   = hdr_cur;
      value_nxt = value_cur;
      num_step  = 1'b0;
      case (hdr_cur.stage)
         NS_NONE: begin
            if (hdr_cur.key_pos < KEY_LEN && lower == keyword_char(hdr_cur.key_pos)) begin
               hdr_nxt.key_pos = hdr_cur.key_pos + 4'd1;
            end else begin
               hdr_nxt.key_pos = (lower == CH_C) ? 4'd1 : 4'd0;
            end
            if (hdr_nxt.key_pos >= KEY_LEN) begin
               hdr_nxt.stage = NS_SKIP;
            end
         end
         NS_SKIP: begin
            if (is_space) begin
               hdr_nxt.stage = NS_SKIP;
            end else if (data_byte == CH_PLUS || data_byte == CH_MINUS) begin
               hdr_nxt.negative = (data_byte == CH_MINUS);
               hdr_nxt.stage    = NS_SIGN;
            end else begin
               num_step = 1'b1;
            end
         end
         NS_SIGN, NS_DIGITS: begin
            num_step = 1'b1;
         end
         default: begin
            num_step = 1'b0;
         end
      endcase
      if (num_step) begin
         if (is_digit) begin
            value_nxt     = accum_sat;
            hdr_nxt.stage = NS_DIGITS;
         end else begin
            hdr_nxt.stage = (hdr_cur.stage == NS_DIGITS) ? NS_DONE : NS_FAIL;
         end
      end

      // cr lf cr lf tracker, four means complete
      if (hdr_cur.term == 2'd0 || hdr_cur.term == 2'd2) begin
         term_nxt = (data_byte == CH_CR) ? 3'(hdr_cur.term) + 3'd1 : 3'd0;
      end else if (data_byte == CH_LF) begin
         term_nxt = 3'(hdr_cur.term) + 3'd1;
      end else begin
         term_nxt = (data_byte == CH_CR) ? 3'd1 : 3'd0;
      end
      hdr_nxt.term = term_nxt[1:0];
      header_end   = (term_nxt == 3'd4);
   end

endmodule

/* dv/tb.sv */
// tb: self-checking bench for rtsp_message_framer. Drives rtsp byte streams over
// rtspmf_req_if, predicts every tagged result beat and checks it on rtspmf_rsp_if.
// Depends on rtspmf_pkg, both channel interfaces and the framer itself.
`timescale 1ns / 1ps

module tb;
   import rtspmf_pkg::*;

   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          RANDOM_BYTES = 1300;
   localparam int          CHUNK_PCT    = 3;
   localparam int          IDLE_PCT     = 11;
   localparam logic [30:0] LIMIT_MAX    = 31'h7fffffff;
   localparam logic [2:0]  TERM_DONE    = 3'd4;
   localparam logic [119:0] LEN_KEY     = "content-length:";
   localparam string       CRLF         = "\015\012";

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_BODY    = 2'd1,
      PH_DISCARD = 2'd2
   } frame_phase_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [1:0]  region;
      logic        message_end;
      logic [30:0] body_length;
      logic [1:0]  error_code;
      logic        chunk_failed;
   } byte_tag_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [30:0] csr_wr_data;

   rtspmf_req_if req_chan ();
   rtspmf_rsp_if rsp_chan ();

   rtsp_message_framer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // framing state of the predictor
   frame_phase_type model_phase;
   logic [2:0]      term_count;
   logic [3:0]      key_count;
   num_stage_type   num_stage;
   logic            len_negative;
   logic [30:0]     len_accum;
   logic [30:0]     body_remaining;
   logic            chunk_had_error;
   logic [30:0]     model_limit;

   byte_tag_type pending_tags[$];
   int        fail_count  = 0;
   int        cycle_count = 0;
   int        bytes_sent  = 0;
   bit        steady_flow;
   bit        hold_toggle;
   int        hold_span;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit is_blank(input logic [7:0] c);
      return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   function automatic void clear_scan();
      term_count   = '0;
      key_count    = '0;
      num_stage    = NS_NONE;
      len_negative = 1'b0;
      len_accum    = '0;
   endfunction

   function automatic void reset_model();
      model_phase     = PH_HEADER;
      clear_scan();
      body_remaining  = '0;
      chunk_had_error = 1'b0;
      model_limit     = BODY_LIMIT_RESET;
      pending_tags.delete();
   endfunction

   // advances the framing state by one byte and returns its expected tag
   task automatic tag_byte(input logic [7:0] c, input logic last, output byte_tag_type t);
      logic [7:0]      lc;
      logic            handled;
      longint unsigned acc;
      t          = '0;
      t.out_byte = c;
      lc = (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'h20 : c;
      case (model_phase)
         PH_BODY: begin
            t.region = REGION_BODY;
            if (body_remaining != 0) body_remaining--;
            if (body_remaining == 0) begin
               t.message_end = 1'b1;
               model_phase   = PH_HEADER;
            end
         end
         PH_DISCARD: t.region = REGION_DISCARD;
         default: begin
            t.region    = REGION_HEADER;
            model_phase = PH_HEADER;
            // keyword match, then sign and digit scan
            handled = 1'b0;
            if (num_stage == NS_NONE) begin
               if (key_count < KEY_LEN && lc == LEN_KEY[8*(14-key_count) +: 8])
                  key_count++;
               else
                  key_count = (lc == CH_C) ? 4'd1 : 4'd0;
               if (key_count >= KEY_LEN) num_stage = NS_SKIP;
               handled = 1'b1;
            end else if (num_stage == NS_SKIP) begin
               if (is_blank(c)) begin
                  handled = 1'b1;
               end else if (c == CH_PLUS || c == CH_MINUS) begin
                  len_negative = (c == CH_MINUS);
                  num_stage    = NS_SIGN;
                  handled      = 1'b1;
               end
            end else if (num_stage != NS_SIGN && num_stage != NS_DIGITS) begin
               handled = 1'b1;
            end
            if (!handled) begin
               if (c >= CH_ZERO && c <= CH_NINE) begin
                  acc       = longint'(len_accum) * 10 + (c - CH_ZERO);
                  len_accum = (acc > LIMIT_MAX) ? LIMIT_MAX : acc[30:0];
                  num_stage = NS_DIGITS;
               end else begin
                  num_stage = (num_stage == NS_DIGITS) ? NS_DONE : NS_FAIL;
               end
            end
            // blank line detection
            if (term_count == 0 || term_count == 2)
               term_count = (c == CH_CR) ? term_count + 1 : 3'd0;
            else if (c == CH_LF)
               term_count++;
            else
               term_count = (c == CH_CR) ? 3'd1 : 3'd0;
            if (term_count == TERM_DONE) begin
               if (num_stage == NS_NONE) begin
                  t.message_end = 1'b1;
               end else if (num_stage != NS_DIGITS && num_stage != NS_DONE) begin
                  t.error_code = ERR_NO_DIGITS;
               end else if (len_negative && len_accum != 0) begin
                  t.error_code = ERR_NEGATIVE;
               end else if (len_accum > model_limit) begin
                  t.error_code = ERR_LIMIT;
               end else begin
                  t.body_length = len_accum;
                  if (len_accum == 0) begin
                     t.message_end = 1'b1;
                  end else begin
                     body_remaining = len_accum;
                     model_phase    = PH_BODY;
                  end
               end
               clear_scan();
               if (t.error_code != ERR_NONE) begin
                  model_phase     = PH_DISCARD;
                  chunk_had_error = 1'b1;
               end
            end
         end
      endcase
      t.chunk_failed = last & chunk_had_error;
      if (last) begin
         chunk_had_error = 1'b0;
         if (model_phase == PH_DISCARD) begin
            model_phase = PH_HEADER;
            clear_scan();
         end
      end
   endtask

   // input side: register writes and accepted bytes feed the predictor
   always @(posedge clock) begin : watch_inputs
      byte_tag_type tag;
      if (reset) begin
         reset_model();
      end else begin
         if (csr_wr_en) model_limit = csr_wr_data;
         if (req_chan.valid && req_chan.ready) begin
            tag_byte(req_chan.data_byte, req_chan.chunk_last, tag);
            pending_tags.push_back(tag);
         end
      end
   end

   function automatic void check_field(input string field, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0h actual %0h", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      byte_tag_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_tags.size() == 0) begin
            $error("result beat with no byte pending, out_byte %0h", rsp_chan.out_byte);
            fail_count++;
         end else begin
            want = pending_tags.pop_front();
            check_field("out_byte", want.out_byte, rsp_chan.out_byte);
            check_field("region", want.region, rsp_chan.region);
            check_field("message_end", want.message_end, rsp_chan.message_end);
            check_field("body_length", want.body_length, rsp_chan.body_length);
            check_field("error_code", want.error_code, rsp_chan.error_code);
            check_field("chunk_failed", want.chunk_failed, rsp_chan.chunk_failed);
         end
      end
   end

   // result ready: random idling, or a counted hold-off when the toggle flips
   initial begin : drive_result_ready
      int hold_left;
      bit hold_seen;
      hold_left      = 0;
      hold_seen      = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = hold_span;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // called and returns at a falling edge; valid stays high between back-to-back beats
   task automatic send_beat(input logic [7:0] b, input logic last);
      if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= b;
      req_chan.chunk_last <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input int chunk_pct, input bit last_at_end);
      for (int i = 0; i < s.len(); i++)
         send_beat(s[i], (last_at_end && i == s.len() - 1) ||
                         $urandom_range(99) < chunk_pct);
   endtask

   task automatic send_filler(input int n, input int chunk_pct);
      for (int i = 0; i < n; i++)
         send_beat(8'($urandom_range(255)), $urandom_range(99) < chunk_pct);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_tags.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [30:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic string random_token(input int n);
      string pool;
      string s;
      pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789/-:.";
      s    = "";
      for (int i = 0; i < n; i++)
         s = $sformatf("%s%c", s, pool[$urandom_range(pool.len() - 1)]);
      return s;
   endfunction

   // one message with random content; some are truncated, some are plain noise
   task automatic send_random_message(input int chunk_pct);
      string      msg;
      string      line;
      logic [7:0] ch;
      int         pick;
      int         len;
      bit         minus;
      pick  = $urandom_range(99);
      len   = 0;
      minus = 1'b0;
      if (pick < 6) begin
         send_filler($urandom_range(1, 12), chunk_pct);
         return;
      end
      msg = {random_token($urandom_range(3, 8)), " * RTSP/1.0", CRLF};
      if ($urandom_range(99) < 80) begin
         line = "";
         for (int i = 0; i < 15; i++) begin
            ch = LEN_KEY[8*(14-i) +: 8];
            if (ch >= "a" && ch <= "z" && $urandom_range(1)) ch = ch ^ 8'h20;
            line = $sformatf("%s%c", line, ch);
         end
         repeat ($urandom_range(0, 2)) line = {line, $urandom_range(1) ? " " : "\t"};
         case ($urandom_range(19))
            0, 1:    line = {line, "+"};
            2:       begin line = {line, "-"}; minus = 1'b1; end
            default: ;
         endcase
         pick = $urandom_range(99);
         if (pick < 80) begin
            len  = $urandom_range(0, 40);
            line = {line, $sformatf("%0d", len)};
         end else if (pick < 88) begin
            line = {line, $urandom_range(1) ? "x" : ""};
         end else if (pick < 94 || model_limit >= 100000) begin
            len  = $urandom_range(0, 40);
            line = {line, $sformatf("00%0d", len)};
         end else begin
            // over the limit, the header fails so no body follows
            line = {line, $sformatf("%0d", model_limit + 31'($urandom_range(1, 1000)))};
         end
         msg = {msg, line, CRLF};
      end
      if ($urandom_range(1)) msg = {msg, "CSeq: ", random_token(2), CRLF};
      msg = {msg, CRLF};
      if ($urandom_range(99) < 4) begin
         // broken message: cut short, the stream simply carries on
         send_text(msg.substr(0, $urandom_range(0, msg.len() - 2)), chunk_pct, 1'b0);
         return;
      end
      send_text(msg, chunk_pct, 1'b0);
      if (!minus) send_filler(len, chunk_pct);
      // after a failed header, close the chunk so parsing picks up again
      if (model_phase == PH_DISCARD) send_filler($urandom_range(1, 4), 100);
   endtask

   task automatic test_plain_headers();
      write_limit(31'd64);
      send_beat(8'h00, 1'b0);
      send_beat(8'hff, 1'b1);
      send_text({"A", CRLF, CRLF}, 0, 1'b0);
   endtask

   task automatic test_content_lengths();
      send_text({"Content-Length: 3", CRLF, CRLF, "xyz"}, 0, 1'b0);
      send_text({"CONTENT-LENGTH:0", CRLF, CRLF}, 0, 1'b0);
      // header and body each cross a chunk boundary
      send_text("content-", 0, 1'b1);
      send_text({"length:\t+007", CRLF, CRLF, "abc"}, 0, 1'b1);
      send_text("defg", 0, 1'b0);
   endtask

   task automatic test_length_errors();
      send_text({"content-length:", CRLF, CRLF, "junk"}, 0, 1'b1);
      // error lands on the chunk's last byte, nothing to discard
      send_text({"content-length: -", CRLF, CRLF}, 0, 1'b1);
      send_text({"content-length: -0", CRLF, CRLF}, 0, 1'b0);
      send_text({"content-length: -12", CRLF, CRLF, "zz"}, 0, 1'b1);
      send_text({"content-length: 99999999999", CRLF, CRLF, "q"}, 0, 1'b1);
   endtask

   task automatic test_limit_extremes();
      write_limit(31'd0);
      send_text({"content-length: 1", CRLF, CRLF, "x"}, 0, 1'b1);
      send_text({"content-length: -5", CRLF, CRLF, "y"}, 0, 1'b1);
      send_text({"content-length: 0", CRLF, CRLF}, 0, 1'b0);
      write_limit(31'd5);
      send_text({"content-length:5", CRLF, CRLF, "12345"}, 0, 1'b0);
      send_text({"content-length:6", CRLF, CRLF, "123456"}, 0, 1'b1);
   endtask

   task automatic test_random_traffic();
      logic [30:0] limits [4];
      int          stop_at;
      limits = '{LIMIT_MAX, 31'd0, 31'd24, 31'($urandom_range(1, 100000))};
      for (int p = 0; p < 4; p++) begin
         write_limit(limits[p]);
         steady_flow <= (p == 2);
         stop_at = bytes_sent + RANDOM_BYTES / 4;
         while (bytes_sent < stop_at) send_random_message(CHUNK_PCT);
      end
   endtask

   // result side holds off long enough for the block to fill and stall its input
   task automatic test_backpressure();
      int stop_at;
      steady_flow <= 1'b0;
      hold_span   <= 200;
      hold_toggle <= ~hold_toggle;
      stop_at = bytes_sent + 150;
      while (bytes_sent < stop_at) send_random_message(CHUNK_PCT);
   endtask

   task automatic test_saturated_length();
      write_limit(LIMIT_MAX);
      send_text({CRLF, CRLF}, 0, 1'b1);
      while (model_phase != PH_HEADER) send_beat(8'($urandom_range(255)), 1'b1);
      send_text({"content-length: 99999999999", CRLF, CRLF}, 0, 1'b0);
      send_filler(6, 0);
   endtask

   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_chan.valid      = 1'b0;
      req_chan.data_byte  = '0;
      req_chan.chunk_last = 1'b0;
      steady_flow         = 1'b0;
      hold_toggle         = 1'b0;
      hold_span           = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_plain_headers();
      test_content_lengths();
      test_length_errors();
      test_limit_extremes();
      test_random_traffic();
      test_backpressure();
      test_saturated_length();

      wait_drained();
      if (fail_count == 0 && pending_tags.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* files.f */
sv/rtspmf_pkg.sv
sv/rtspmf_req_if.sv
sv/rtspmf_rsp_if.sv
sv/rtspmf_header_scan.sv
sv/rtsp_message_framer.sv
dv/tb.sv
